@@ hdl/rsvm_pkg.sv @@
package rsvm_pkg;

   localparam int DATA_W          = 32;
   localparam int NUM_REGS_DEF    = 8;
   localparam int STACK_DEPTH_DEF = 16;
   localparam int CNT_W           = $clog2(DATA_W);

   localparam logic [DATA_W-1:0] SIGN_BIT = 32'h8000_0000;

   // opcodes
   localparam logic [4:0] OP_MOV  = 5'd0;
   localparam logic [4:0] OP_ADD  = 5'd1;
   localparam logic [4:0] OP_SUB  = 5'd2;
   localparam logic [4:0] OP_MUL  = 5'd3;
   localparam logic [4:0] OP_DIV  = 5'd4;
   localparam logic [4:0] OP_AND  = 5'd5;
   localparam logic [4:0] OP_OR   = 5'd6;
   localparam logic [4:0] OP_XOR  = 5'd7;
   localparam logic [4:0] OP_NOT  = 5'd8;
   localparam logic [4:0] OP_PUSH = 5'd9;
   localparam logic [4:0] OP_POP  = 5'd10;
   localparam logic [4:0] OP_JMP  = 5'd11;
   localparam logic [4:0] OP_CMP  = 5'd12;
   localparam logic [4:0] OP_JE   = 5'd13;
   localparam logic [4:0] OP_JNE  = 5'd14;
   localparam logic [4:0] OP_JZ   = 5'd15;
   localparam logic [4:0] OP_JNZ  = 5'd16;
   localparam logic [4:0] OP_INC  = 5'd17;
   localparam logic [4:0] OP_DEC  = 5'd18;
   localparam logic [4:0] OP_NOP  = 5'd19;

   // fault codes
   localparam logic [2:0] FLT_NONE  = 3'd0;
   localparam logic [2:0] FLT_DIV0  = 3'd1;
   localparam logic [2:0] FLT_OVFL  = 3'd2;
   localparam logic [2:0] FLT_UNFL  = 3'd3;
   localparam logic [2:0] FLT_UNKN  = 3'd4;

   typedef struct packed {
      logic [4:0]        command;
      logic [2:0]        dest_reg;
      logic              source_is_immediate;
      logic [2:0]        source_reg;
      logic [DATA_W-1:0] source_immediate;
   } req_type;

   typedef struct packed {
      logic [DATA_W-1:0] next_pc;
      logic [DATA_W-1:0] dest_value;
      logic              reg_written;
      logic              zero_flag;
      logic              carry_flag;
      logic              sign_flag;
      logic              overflow_flag;
      logic [2:0]        fault;
   } rsp_type;

   typedef struct packed {
      logic z;
      logic c;
      logic s;
      logic o;
   } flags_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_ITER,
      ST_DONE
   } st_type;

   // register index modulo the register count (raw index is only 3 bits)
   function automatic logic [2:0] rsvm_wrap(input logic [2:0] raw, input int unsigned n);
      logic [5:0] v;
      v = {3'b000, raw};
      for (int i = 0; i < 4; i++) begin
         if (32'(v) >= n) begin
            v = v - 6'(n);
         end
      end
      return v[2:0];
   endfunction

endpackage

@@ hdl/register_stack_vm_execute.sv @@
// Execute unit for a small two-operand 32-bit machine. Each req transaction
// carries one decoded instruction; each rsp transaction returns the next
// program counter, the register write (if any), the current ZF/CF/SF/OF flags
// and a fault code. req_ready is high only while the unit is idle. A plain
// instruction passes through accept, execute and commit steps; MUL and DIV
// add 32 shift-add or shift-subtract passes through the one shared 33-bit
// adder/subtractor before commit, except a divide by zero, which faults
// without them. The commit cycle waits while a previous rsp transaction is
// still held in the output register. Reset clears the register file, program
// counter, flags and stack depth; stack contents are not cleared, and the
// depth count only lets pushed entries be read. A faulting instruction
// changes no state.
module register_stack_vm_execute #(
   parameter int NUM_REGS    = rsvm_pkg::NUM_REGS_DEF,
   parameter int STACK_DEPTH = rsvm_pkg::STACK_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  rsvm_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rsvm_pkg::rsp_type rsp_data
);
   import rsvm_pkg::*;

   localparam int RIDX_W = $clog2(NUM_REGS);
   localparam int SIDX_W = $clog2(STACK_DEPTH);
   localparam int SP_W   = $clog2(STACK_DEPTH + 1);

   // state
   st_type st_ff, st_in;
   logic   accept, commit;

   // architectural state
   logic [DATA_W-1:0] rf_mem [NUM_REGS];
   logic [NUM_REGS-1:0] rf_vld_ff;
   logic [DATA_W-1:0] stk_mem [STACK_DEPTH];
   logic [SP_W-1:0]   sp_ff, sp_dec;
   logic [DATA_W-1:0] pc_ff;
   flags_type         flg_ff;

   // captured instruction and registered reads
   req_type           req_ff;
   logic [RIDX_W-1:0] addr_a, addr_b, d_idx;
   logic [DATA_W-1:0] rd_a_ff, rd_b_ff, stk_rd_ff;
   logic              rd_a_vld_ff, rd_b_vld_ff;
   logic [DATA_W-1:0] dv, src;

   // shared unit
   logic [DATA_W:0]   alu_a, alu_b;
   logic              alu_sub;
   logic [DATA_W+1:0] alu_sum;

   // iteration registers
   logic [DATA_W-1:0] opa_ff, opa_in, opb_ff, opb_in;
   logic [DATA_W-1:0] acc_ff, acc_in, quo_ff, quo_in, acc_nxt, quo_nxt;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              is_div, iter_last;

   // pending result
   logic [DATA_W-1:0] res_val_ff, res_val_in, res_npc_ff, res_npc_in;
   logic              res_wr_ff, res_wr_in, res_push_ff, res_push_in;
   logic              res_pop_ff, res_pop_in;
   logic [RIDX_W-1:0] res_wreg_ff, res_wreg_in;
   logic [2:0]        res_flt_ff, res_flt_in;
   flags_type         res_flg_ff, res_flg_in;

   rsp_type           rsp_ff;
   logic              rsp_valid_ff;

   // ---------------------------------------------------------------- control
   always_comb begin
      req_ready = (st_ff == ST_IDLE);
      accept    = req_valid && req_ready;
      commit    = (st_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);
      rsp_valid = rsp_valid_ff;
      rsp_data  = rsp_ff;
   end

   always_comb begin
      st_in = st_ff;
      case (st_ff)
         ST_IDLE: begin
            if (accept) begin
               st_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if ((req_ff.command == OP_MUL) || ((req_ff.command == OP_DIV) && (src != '0))) begin
               st_in = ST_ITER;
            end else begin
               st_in = ST_DONE;
            end
         end
         ST_ITER: begin
            if (iter_last) begin
               st_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (commit) begin
               st_in = ST_IDLE;
            end
         end
         default: st_in = ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------- operands
   always_comb begin
      addr_a = RIDX_W'(rsvm_wrap(req_data.dest_reg, NUM_REGS));
      if (req_data.command inside {OP_MUL, OP_DIV}) begin
         addr_a = '0;
      end
      addr_b = RIDX_W'(rsvm_wrap(req_data.source_reg, NUM_REGS));
      d_idx  = RIDX_W'(rsvm_wrap(req_ff.dest_reg, NUM_REGS));
      sp_dec = sp_ff - SP_W'(1);
      dv     = rd_a_vld_ff ? rd_a_ff : '0;
      src    = req_ff.source_is_immediate ? req_ff.source_immediate :
               (rd_b_vld_ff ? rd_b_ff : '0);
      is_div    = (req_ff.command == OP_DIV);
      iter_last = (cnt_ff == CNT_W'(DATA_W - 1));
   end

   // ---------------------------------------------------------------- shared add/subtract unit
   always_comb begin
      alu_a   = '0;
      alu_b   = '0;
      alu_sub = 1'b0;
      case (st_ff)
         ST_EXEC: begin
            alu_a   = {1'b0, dv};
            alu_b   = {1'b0, (req_ff.command inside {OP_INC, OP_DEC}) ? DATA_W'(1) : src};
            alu_sub = req_ff.command inside {OP_SUB, OP_CMP, OP_DEC};
         end
         ST_ITER: begin
            if (is_div) begin
               // restoring divide: trial subtract of the divisor
               alu_a   = {acc_ff, quo_ff[DATA_W-1]};
               alu_b   = {1'b0, opb_ff};
               alu_sub = 1'b1;
            end else begin
               // shift-add multiply, multiplier MSB first
               alu_a = {1'b0, acc_ff[DATA_W-2:0], 1'b0};
               alu_b = {1'b0, quo_ff[DATA_W-1] ? opa_ff : '0};
            end
         end
         default: ;
      endcase
      alu_sum = alu_sub ? ({1'b0, alu_a} - {1'b0, alu_b}) : ({1'b0, alu_a} + {1'b0, alu_b});
   end

   // ---------------------------------------------------------------- datapath next values
   always_comb begin
      opa_in      = opa_ff;
      opb_in      = opb_ff;
      acc_in      = acc_ff;
      quo_in      = quo_ff;
      cnt_in      = cnt_ff;
      res_val_in  = res_val_ff;
      res_npc_in  = res_npc_ff;
      res_wr_in   = res_wr_ff;
      res_wreg_in = res_wreg_ff;
      res_flt_in  = res_flt_ff;
      res_flg_in  = res_flg_ff;
      res_push_in = res_push_ff;
      res_pop_in  = res_pop_ff;

      if (is_div) begin
         if (!alu_sum[DATA_W+1]) begin
            acc_nxt = alu_sum[DATA_W-1:0];
            quo_nxt = {quo_ff[DATA_W-2:0], 1'b1};
         end else begin
            acc_nxt = {acc_ff[DATA_W-2:0], quo_ff[DATA_W-1]};
            quo_nxt = {quo_ff[DATA_W-2:0], 1'b0};
         end
      end else begin
         acc_nxt = alu_sum[DATA_W-1:0];
         quo_nxt = {quo_ff[DATA_W-2:0], 1'b0};
      end

      case (st_ff)
         ST_EXEC: begin
            res_npc_in  = pc_ff + DATA_W'(1);
            res_val_in  = '0;
            res_wr_in   = 1'b0;
            res_wreg_in = d_idx;
            res_flt_in  = FLT_NONE;
            res_flg_in  = flg_ff;
            res_push_in = 1'b0;
            res_pop_in  = 1'b0;
            acc_in      = '0;
            cnt_in      = '0;
            case (req_ff.command)
               OP_MOV: begin
                  res_val_in = src;
                  res_wr_in  = 1'b1;
               end
               OP_ADD, OP_SUB, OP_INC, OP_DEC: begin
                  res_val_in = alu_sum[DATA_W-1:0];
                  res_wr_in  = 1'b1;
               end
               OP_MUL: begin
                  opa_in      = dv;
                  quo_in      = src;
                  res_wreg_in = '0;
               end
               OP_DIV: begin
                  if (src == '0) begin
                     res_flt_in = FLT_DIV0;
                  end else begin
                     opb_in      = src;
                     quo_in      = dv;
                     res_wreg_in = '0;
                  end
               end
               OP_AND: begin
                  res_val_in = dv & src;
                  res_wr_in  = 1'b1;
               end
               OP_OR: begin
                  res_val_in = dv | src;
                  res_wr_in  = 1'b1;
               end
               OP_XOR: begin
                  res_val_in = dv ^ src;
                  res_wr_in  = 1'b1;
               end
               OP_NOT: begin
                  res_val_in = ~dv;
                  res_wr_in  = 1'b1;
               end
               OP_PUSH: begin
                  if (sp_ff >= SP_W'(STACK_DEPTH)) begin
                     res_flt_in = FLT_OVFL;
                  end else begin
                     opb_in      = src;
                     res_push_in = 1'b1;
                  end
               end
               OP_POP: begin
                  if (sp_ff == '0) begin
                     res_flt_in = FLT_UNFL;
                  end else begin
                     res_val_in = stk_rd_ff;
                     res_wr_in  = 1'b1;
                     res_pop_in = 1'b1;
                  end
               end
               OP_JMP: res_npc_in = dv;
               OP_CMP: begin
                  res_flg_in.z = (alu_sum[DATA_W-1:0] == '0);
                  res_flg_in.c = alu_sum[DATA_W+1];
                  res_flg_in.s = alu_sum[DATA_W-1];
                  res_flg_in.o = (((dv & SIGN_BIT) != '0) != ((src & SIGN_BIT) != '0)) &&
                                 (alu_sum[DATA_W-1] != ((dv & SIGN_BIT) != '0));
               end
               OP_JE, OP_JZ: begin
                  if (flg_ff.z) begin
                     res_npc_in = src;
                  end
               end
               OP_JNE, OP_JNZ: begin
                  if (!flg_ff.z) begin
                     res_npc_in = src;
                  end
               end
               OP_NOP: ;
               default: res_flt_in = FLT_UNKN;
            endcase
            if (res_flt_in != FLT_NONE) begin
               res_npc_in = pc_ff;
            end
         end
         ST_ITER: begin
            acc_in = acc_nxt;
            quo_in = quo_nxt;
            cnt_in = cnt_ff + CNT_W'(1);
            if (iter_last) begin
               res_val_in = is_div ? quo_nxt : acc_nxt;
               res_wr_in  = 1'b1;
            end
         end
         default: ;
      endcase
   end

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= ST_IDLE;
         rf_vld_ff    <= '0;
         sp_ff        <= '0;
         pc_ff        <= '0;
         flg_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         if (commit) begin
            if (res_wr_ff) begin
               rf_vld_ff[res_wreg_ff] <= 1'b1;
            end
            if (res_push_ff) begin
               sp_ff <= sp_ff + SP_W'(1);
            end else if (res_pop_ff) begin
               sp_ff <= sp_dec;
            end
            pc_ff        <= res_npc_ff;
            flg_ff       <= res_flg_ff;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff      <= req_data;
         rd_a_ff     <= rf_mem[addr_a];
         rd_b_ff     <= rf_mem[addr_b];
         rd_a_vld_ff <= rf_vld_ff[addr_a];
         rd_b_vld_ff <= rf_vld_ff[addr_b];
         stk_rd_ff   <= stk_mem[sp_dec[SIDX_W-1:0]];
      end
      if (commit) begin
         if (res_wr_ff) begin
            rf_mem[res_wreg_ff] <= res_val_ff;
         end
         if (res_push_ff) begin
            stk_mem[sp_ff[SIDX_W-1:0]] <= opb_ff;
         end
         rsp_ff.next_pc       <= res_npc_ff;
         rsp_ff.dest_value    <= res_wr_ff ? res_val_ff : '0;
         rsp_ff.reg_written   <= res_wr_ff;
         rsp_ff.zero_flag     <= res_flg_ff.z;
         rsp_ff.carry_flag    <= res_flg_ff.c;
         rsp_ff.sign_flag     <= res_flg_ff.s;
         rsp_ff.overflow_flag <= res_flg_ff.o;
         rsp_ff.fault         <= res_flt_ff;
      end
      opa_ff      <= opa_in;
      opb_ff      <= opb_in;
      acc_ff      <= acc_in;
      quo_ff      <= quo_in;
      cnt_ff      <= cnt_in;
      res_val_ff  <= res_val_in;
      res_npc_ff  <= res_npc_in;
      res_wr_ff   <= res_wr_in;
      res_wreg_ff <= res_wreg_in;
      res_flt_ff  <= res_flt_in;
      res_flg_ff  <= res_flg_in;
      res_push_ff <= res_push_in;
      res_pop_ff  <= res_pop_in;
   end

   // ---------------------------------------------------------------- assertions
   a_fault_no_write: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((rsp_ff.fault == FLT_NONE) ||
                        (!rsp_ff.reg_written && (rsp_ff.dest_value == '0))))
      else $error("faulting transaction reports a register write");

   a_sp_bound: assert property (@(posedge clock) disable iff (reset)
      sp_ff <= SP_W'(STACK_DEPTH))
      else $error("stack depth beyond capacity");

   a_iter_op: assert property (@(posedge clock) disable iff (reset)
      (st_ff == ST_ITER) |-> ((req_ff.command == OP_MUL) || (req_ff.command == OP_DIV)))
      else $error("iteration running for a single-cycle opcode");

   a_fault_pc_hold: assert property (@(posedge clock) disable iff (reset)
      (commit && (res_flt_ff != FLT_NONE)) |=> (pc_ff == $past(pc_ff)))
      else $error("program counter moved on a fault");

   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      accept |=> (st_ff == ST_EXEC))
      else $error("accepted transaction did not start execution");

endmodule

@@ sim/vm_exec_checker.sv @@
`timescale 1ns / 100ps

module vm_exec_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  rsvm_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  rsvm_pkg::rsp_type rsp_data,
   output int                outstanding,
   output int                mismatches,
   output int                checked,
   output int                faulted
);
   import rsvm_pkg::*;

   // architectural state as the unit should hold it
   logic [DATA_W-1:0] gpr [NUM_REGS_DEF];
   logic [DATA_W-1:0] stack_mem [STACK_DEPTH_DEF];
   logic [DATA_W-1:0] pc;
   flags_type         cond;
   int                stack_ptr;

   rsp_type pending_outcomes [$];

   task automatic clear_machine();
      for (int i = 0; i < NUM_REGS_DEF; i++) begin
         gpr[i] = '0;
      end
      for (int i = 0; i < STACK_DEPTH_DEF; i++) begin
         stack_mem[i] = '0;
      end
      pc        = '0;
      cond      = '0;
      stack_ptr = 0;
   endtask

   // 8 registers and a 3-bit index: no wrap needed
   function automatic rsp_type execute_instruction(input req_type ins);
      rsp_type           o;
      logic [DATA_W-1:0] src;
      logic [DATA_W-1:0] lhs;
      logic [DATA_W-1:0] npc;
      logic [DATA_W-1:0] wval;
      logic [DATA_W-1:0] diff;
      logic [2:0]        wreg;
      logic              wr;
      logic [2:0]        flt;
      src  = ins.source_is_immediate ? ins.source_immediate : gpr[ins.source_reg];
      lhs  = gpr[ins.dest_reg];
      npc  = pc + 32'd1;
      wreg = ins.dest_reg;
      wval = '0;
      wr   = 1'b0;
      flt  = FLT_NONE;
      case (ins.command)
         OP_MOV: begin
            wval = src;
            wr   = 1'b1;
         end
         OP_ADD: begin
            wval = lhs + src;
            wr   = 1'b1;
         end
         OP_SUB: begin
            wval = lhs - src;
            wr   = 1'b1;
         end
         OP_MUL: begin
            wreg = 3'd0;
            wval = gpr[0] * src;
            wr   = 1'b1;
         end
         OP_DIV: begin
            if (src == '0) begin
               flt = FLT_DIV0;
            end else begin
               wreg = 3'd0;
               wval = gpr[0] / src;
               wr   = 1'b1;
            end
         end
         OP_AND: begin
            wval = lhs & src;
            wr   = 1'b1;
         end
         OP_OR: begin
            wval = lhs | src;
            wr   = 1'b1;
         end
         OP_XOR: begin
            wval = lhs ^ src;
            wr   = 1'b1;
         end
         OP_NOT: begin
            wval = ~lhs;
            wr   = 1'b1;
         end
         OP_PUSH: begin
            if (stack_ptr >= STACK_DEPTH_DEF) begin
               flt = FLT_OVFL;
            end else begin
               stack_mem[stack_ptr] = src;
               stack_ptr++;
            end
         end
         OP_POP: begin
            if (stack_ptr == 0) begin
               flt = FLT_UNFL;
            end else begin
               stack_ptr--;
               wval = stack_mem[stack_ptr];
               wr   = 1'b1;
            end
         end
         OP_JMP: begin
            npc = lhs;
         end
         OP_CMP: begin
            diff   = lhs - src;
            cond.z = (diff == '0);
            cond.c = (lhs < src);
            cond.s = diff[DATA_W-1];
            cond.o = (lhs[DATA_W-1] != src[DATA_W-1]) && (diff[DATA_W-1] != lhs[DATA_W-1]);
         end
         OP_JE, OP_JZ: begin
            if (cond.z) begin
               npc = src;
            end
         end
         OP_JNE, OP_JNZ: begin
            if (!cond.z) begin
               npc = src;
            end
         end
         OP_INC: begin
            wval = lhs + 32'd1;
            wr   = 1'b1;
         end
         OP_DEC: begin
            wval = lhs - 32'd1;
            wr   = 1'b1;
         end
         OP_NOP: begin
         end
         default: begin
            flt = FLT_UNKN;
         end
      endcase

      // a faulting instruction leaves everything as it was
      if (flt != FLT_NONE) begin
         npc  = pc;
         wr   = 1'b0;
         wval = '0;
      end else begin
         if (wr) begin
            gpr[wreg] = wval;
         end
         pc = npc;
      end

      o.next_pc       = npc;
      o.dest_value    = wval;
      o.reg_written   = wr;
      o.zero_flag     = cond.z;
      o.carry_flag    = cond.c;
      o.sign_flag     = cond.s;
      o.overflow_flag = cond.o;
      o.fault         = flt;
      return o;
   endfunction

   task automatic check_field(input string field, input logic [DATA_W-1:0] want,
                              input logic [DATA_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%h, got 0x%h", field, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin : monitor
      rsp_type want;
      if (reset) begin
         clear_machine();
         pending_outcomes.delete();
         mismatches = 0;
         checked    = 0;
         faulted    = 0;
      end else begin
         if (req_valid && req_ready) begin
            pending_outcomes.insert(pending_outcomes.size(), execute_instruction(req_data));
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_outcomes.size() == 0) begin
               $error("result transaction with nothing outstanding: 0x%h", rsp_data);
               mismatches++;
            end else begin
               want = pending_outcomes.pop_front();
               check_field("next_pc", want.next_pc, rsp_data.next_pc);
               check_field("dest_value", want.dest_value, rsp_data.dest_value);
               check_field("reg_written", DATA_W'(want.reg_written),
                           DATA_W'(rsp_data.reg_written));
               check_field("zero_flag", DATA_W'(want.zero_flag),
                           DATA_W'(rsp_data.zero_flag));
               check_field("carry_flag", DATA_W'(want.carry_flag),
                           DATA_W'(rsp_data.carry_flag));
               check_field("sign_flag", DATA_W'(want.sign_flag),
                           DATA_W'(rsp_data.sign_flag));
               check_field("overflow_flag", DATA_W'(want.overflow_flag),
                           DATA_W'(rsp_data.overflow_flag));
               check_field("fault", DATA_W'(want.fault), DATA_W'(rsp_data.fault));
               checked++;
               if (want.fault != FLT_NONE) begin
                  faulted++;
               end
            end
         end
      end
      outstanding <= pending_outcomes.size();
   end

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 100ps

module tb;
   import rsvm_pkg::*;

   // opcodes the unit does not decode
   localparam logic [4:0] OP_UNUSED_LO = 5'd20;
   localparam logic [4:0] OP_UNUSED_HI = 5'd31;

   localparam int RANDOM_ITEMS = 1000;
   localparam int PHASE_ITEMS  = 150;
   localparam int STALL_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 60;

   logic    clock = 1'b0;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   int outstanding;
   int mismatches;
   int checked;
   int faulted;
   int sent;
   int directed_count;
   int idle_cycles;
   bit steady;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   register_stack_vm_execute u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   vm_exec_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .outstanding (outstanding),
      .mismatches  (mismatches),
      .checked     (checked),
      .faulted     (faulted)
   );

   // mostly back to back, some short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      if (steady) begin
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 55) begin
         return 0;
      end
      if (r < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   function automatic req_type instr(input logic [4:0] cmd, input int d, input int use_imm,
                                     input int s, input logic [DATA_W-1:0] imm);
      req_type ins;
      ins.command             = cmd;
      ins.dest_reg            = 3'(d);
      ins.source_is_immediate = 1'(use_imm);
      ins.source_reg          = 3'(s);
      ins.source_immediate    = imm;
      return ins;
   endfunction

   function automatic req_type random_instr();
      req_type ins;
      int      pick;
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
         ins.command = 5'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
      end else begin
         ins.command = 5'($urandom_range(OP_MOV, OP_NOP));
      end
      ins.dest_reg            = 3'($urandom_range(0, 7));
      ins.source_is_immediate = 1'($urandom_range(0, 1));
      ins.source_reg          = 3'($urandom_range(0, 7));
      case ($urandom_range(0, 11))
         0:       ins.source_immediate = '0;
         1:       ins.source_immediate = '1;
         2:       ins.source_immediate = SIGN_BIT;
         3:       ins.source_immediate = SIGN_BIT - 32'd1;
         4:       ins.source_immediate = 32'd1;
         5:       ins.source_immediate = 32'($urandom_range(1, 16));
         default: ins.source_immediate = $urandom;
      endcase
      return ins;
   endfunction

   // valid stays up across back-to-back transactions
   task automatic send(input req_type item);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      sent++;
   endtask

   initial begin : rsp_side
      int run;
      rsp_ready <= 1'b0;
      @(posedge clock);
      forever begin
         rsp_ready <= 1'b1;
         run = $urandom_range(1, 30);
         repeat (run) @(posedge clock);
         run = pick_gap();
         if (run > 0) begin
            rsp_ready <= 1'b0;
            repeat (run) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : watchdog
      @(posedge clock);
      while (idle_cycles < STALL_LIMIT) @(posedge clock);
      $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
      $display("FAIL");
      $finish;
   end

   initial begin : stimulus
      req_type item;
      int      phase_left;
      int      phase_no;
      int      run;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      sent       = 0;
      steady     = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      send(instr(OP_MOV, 1, 1, 0, '1));
      send(instr(OP_MOV, 2, 1, 0, SIGN_BIT));
      send(instr(OP_MOV, 0, 1, 0, SIGN_BIT - 32'd1));
      send(instr(OP_ADD, 1, 0, 1, '0));          // wraps
      send(instr(OP_SUB, 3, 1, 0, 32'd1));       // borrow out of zero
      send(instr(OP_MUL, 5, 1, 0, '1));
      send(instr(OP_DIV, 5, 1, 0, '0));          // divide by zero
      send(instr(OP_DIV, 5, 0, 2, '0));
      send(instr(OP_AND, 1, 1, 0, 32'hA5A5_A5A5));
      send(instr(OP_OR, 3, 0, 1, '0));
      send(instr(OP_XOR, 7, 1, 0, '1));
      send(instr(OP_NOT, 6, 1, 0, '0));
      send(instr(OP_POP, 4, 1, 0, '0));          // empty stack
      send(instr(OP_PUSH, 0, 1, 0, '0));
      send(instr(OP_POP, 5, 1, 0, '0));
      send(instr(OP_CMP, 2, 1, 0, 32'd1));       // signed overflow
      send(instr(OP_JNE, 0, 1, 0, '1));
      send(instr(OP_JZ, 0, 1, 0, 32'd5));
      send(instr(OP_CMP, 2, 0, 2, '0));          // equal
      send(instr(OP_JE, 0, 1, 0, 32'h0000_1234));
      send(instr(OP_JNZ, 0, 0, 3, '0));
      send(instr(OP_JMP, 6, 1, 0, '0));
      send(instr(OP_INC, 7, 1, 0, '0));
      send(instr(OP_DEC, 4, 1, 0, '0));
      send(instr(OP_NOP, 0, 1, 0, '0));
      send(instr(OP_UNUSED_LO, 0, 1, 0, '0));
      send(instr(OP_UNUSED_HI, 7, 0, 7, '1));
      directed_count = sent;

      phase_left = PHASE_ITEMS;
      phase_no   = 0;
      while (sent < directed_count + RANDOM_ITEMS) begin
         if (phase_left <= 0) begin
            phase_no++;
            phase_left = PHASE_ITEMS;
            steady     = (phase_no % 3 == 1);
         end
         run = $urandom_range(0, 99);
         if (run < 4 || sent == directed_count) begin
            // long push run to hit a full stack
            repeat ($urandom_range(STACK_DEPTH_DEF - 3, STACK_DEPTH_DEF + 3)) begin
               item         = random_instr();
               item.command = OP_PUSH;
               send(item);
            end
         end else if (run < 8 || sent == directed_count + 20) begin
            // long pop run to drain and underflow
            repeat ($urandom_range(STACK_DEPTH_DEF - 3, STACK_DEPTH_DEF + 3)) begin
               item         = random_instr();
               item.command = OP_POP;
               send(item);
            end
         end else if (run < 25) begin
            item         = random_instr();
            item.command = OP_CMP;
            send(item);
            item = random_instr();
            case ($urandom_range(0, 3))
               0:       item.command = OP_JE;
               1:       item.command = OP_JNE;
               2:       item.command = OP_JZ;
               default: item.command = OP_JNZ;
            endcase
            send(item);
         end else begin
            send(random_instr());
         end
         phase_left = phase_left - 1;
      end
      req_valid <= 1'b0;

      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d instructions driven (%0d directed), %0d results compared, %0d faulted",
               sent, directed_count, checked, faulted);
      $display("covered every opcode, undecoded opcodes, divide by zero, both stack limits");
      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
